// ----- src/asis_pkg.sv -----
// Shared types for the ascending integer sorter.
// Holds the state encodings and the status bundle passed from the sort engine.
// No dependencies.
`default_nettype none

package asis_pkg;

  typedef enum logic [3:0] {
    TOP_COLLECT = 4'b0001,
    TOP_SORT    = 4'b0010,
    TOP_READ    = 4'b0100,
    TOP_SHOW    = 4'b1000
  } top_state_t;

  typedef enum logic [4:0] {
    SRT_IDLE  = 5'b00001,
    SRT_START = 5'b00010,
    SRT_LOAD  = 5'b00100,
    SRT_RUN   = 5'b01000,
    SRT_END   = 5'b10000
  } srt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srt_status_t;

endpackage

`default_nettype wire

// ----- src/asis_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module asis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/asis_sorter.sv -----
// Bubble-pass engine that sorts the first n entries of the element RAM in place.
// Depends on asis_pkg; drives the RAM ports while a sort is running.
`default_nettype none

module asis_sorter #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [$clog2(CAPACITY+1)-1:0]     n_elems,
  input  wire logic [DATA_WIDTH-1:0]             rdata,
  output logic      [$clog2(CAPACITY)-1:0]       raddr,
  output logic                                   we,
  output logic      [$clog2(CAPACITY)-1:0]       waddr,
  output logic      [DATA_WIDTH-1:0]             wdata,
  output asis_pkg::srt_status_t                  status
);

  localparam int AW = $clog2(CAPACITY);

  asis_pkg::srt_state_t state_r, state_nxt;
  logic [AW-1:0]         limit_r, limit_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] carry_r, carry_nxt;
  logic                  greater;

  assign greater = $signed(carry_r) > $signed(rdata);

  always_comb begin
    state_nxt   = state_r;
    limit_nxt   = limit_r;
    pos_nxt     = pos_r;
    carry_nxt   = carry_r;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = carry_r;
    status.busy = (state_r != asis_pkg::SRT_IDLE);
    status.done = 1'b0;
    case (state_r)
      asis_pkg::SRT_IDLE: begin
        if (start) begin
          limit_nxt = AW'(n_elems - 1'b1);
          state_nxt = asis_pkg::SRT_START;
        end
      end
      asis_pkg::SRT_START: begin
        raddr     = '0;
        state_nxt = asis_pkg::SRT_LOAD;
      end
      asis_pkg::SRT_LOAD: begin
        carry_nxt = rdata;
        raddr     = AW'(1);
        pos_nxt   = AW'(1);
        state_nxt = asis_pkg::SRT_RUN;
      end
      asis_pkg::SRT_RUN: begin
        // The larger of the pair travels on; the smaller settles one place down.
        we        = 1'b1;
        waddr     = pos_r - 1'b1;
        wdata     = greater ? rdata : carry_r;
        carry_nxt = greater ? carry_r : rdata;
        if (pos_r == limit_r) begin
          raddr     = pos_r;
          state_nxt = asis_pkg::SRT_END;
        end else begin
          raddr     = pos_r + 1'b1;
          pos_nxt   = pos_r + 1'b1;
        end
      end
      asis_pkg::SRT_END: begin
        we    = 1'b1;
        waddr = limit_r;
        wdata = carry_r;
        if (limit_r == AW'(1)) begin
          status.done = 1'b1;
          state_nxt   = asis_pkg::SRT_IDLE;
        end else begin
          limit_nxt = limit_r - 1'b1;
          state_nxt = asis_pkg::SRT_START;
        end
      end
      default: begin
        state_nxt = asis_pkg::SRT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asis_pkg::SRT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    limit_r <= limit_nxt;
    pos_r   <= pos_nxt;
    carry_r <= carry_nxt;
  end

endmodule

`default_nettype wire

// ----- src/ascending_integer_sorter_top.sv -----
// Top level of the ascending integer sorter: collection, sort hand-off and emission.
// Depends on asis_pkg, asis_ram and asis_sorter.
`default_nettype none

// Collects a run of signed elements, one item per cycle, into a RAM of CAPACITY
// entries; items past capacity are dropped and flag every result of the run as
// overflow. The item marked last starts, for a run of two or more, an in-place
// bubble sort over the single RAM write port and registered read port; each pass
// carries the larger of each pair up and writes the smaller one place down.
// Results are then read back smallest first, each read from the RAM before it is
// shown; the next is read only after one is taken. No input item is accepted from
// the last item of a run until the final result of that run has been taken.
module ascending_integer_sorter_top #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_value,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_sorted_value,
  output logic                              out_end_of_run,
  output logic                              out_overflow
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  asis_pkg::top_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic          drop_r, drop_nxt;

  logic                  in_acc, out_acc, has_room, sort_start, last_out;
  logic [CW-1:0]         run_len;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  srt_we;
  logic [AW-1:0]         srt_waddr, srt_raddr;
  logic [DATA_WIDTH-1:0] srt_wdata;
  asis_pkg::srt_status_t srt_status;

  assign in_ready   = (state_r == asis_pkg::TOP_COLLECT);
  assign out_valid  = (state_r == asis_pkg::TOP_SHOW);
  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign has_room   = (count_r < CAP_C);
  assign run_len    = has_room ? (count_r + 1'b1) : count_r;
  assign sort_start = in_acc && in_last && (run_len >= CW'(2));
  assign last_out   = (emit_r == count_r - 1'b1);

  assign out_sorted_value = $signed(ram_rdata);
  assign out_end_of_run   = last_out;
  assign out_overflow     = drop_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    emit_nxt  = emit_r;
    drop_nxt  = drop_r;
    case (state_r)
      asis_pkg::TOP_COLLECT: begin
        if (in_acc) begin
          count_nxt = run_len;
          drop_nxt  = drop_r || !has_room;
          if (in_last) begin
            emit_nxt  = '0;
            state_nxt = sort_start ? asis_pkg::TOP_SORT : asis_pkg::TOP_READ;
          end
        end
      end
      asis_pkg::TOP_SORT: begin
        if (srt_status.done) begin
          state_nxt = asis_pkg::TOP_READ;
        end
      end
      asis_pkg::TOP_READ: begin
        state_nxt = asis_pkg::TOP_SHOW;
      end
      asis_pkg::TOP_SHOW: begin
        if (out_acc) begin
          if (last_out) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = asis_pkg::TOP_COLLECT;
          end else begin
            emit_nxt  = emit_r + 1'b1;
            state_nxt = asis_pkg::TOP_READ;
          end
        end
      end
      default: begin
        state_nxt = asis_pkg::TOP_COLLECT;
      end
    endcase
  end

  // The sort engine owns the RAM ports while it runs.
  always_comb begin
    if (state_r == asis_pkg::TOP_SORT) begin
      ram_we    = srt_we;
      ram_waddr = srt_waddr;
      ram_wdata = srt_wdata;
      ram_raddr = srt_raddr;
    end else begin
      ram_we    = in_acc && has_room;
      ram_waddr = count_r[AW-1:0];
      ram_wdata = in_value;
      ram_raddr = emit_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asis_pkg::TOP_COLLECT;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
    emit_r <= emit_nxt;
  end

  asis_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  asis_sorter #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_sorter (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sort_start),
    .n_elems (run_len),
    .rdata   (ram_rdata),
    .raddr   (srt_raddr),
    .we      (srt_we),
    .waddr   (srt_waddr),
    .wdata   (srt_wdata),
    .status  (srt_status)
  );

endmodule

`default_nettype wire

// ----- src/asis_checker.sv -----
// Port-level checks for the ascending integer sorter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module asis_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic signed [DATA_WIDTH-1:0] in_value,
  input wire logic                         in_last,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [DATA_WIDTH-1:0] out_sorted_value,
  input wire logic                         out_end_of_run,
  input wire logic                         out_overflow
);

  // A result waiting to be taken must not change under the consumer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_value)
      && $stable(out_end_of_run) && $stable(out_overflow))
    else $error("stalled result changed");

  // Input is never taken while results of a run are being emitted.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready during emission");

  // Closing a run with the last item stops input until results come out.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input accepted after last item");

  // Taking the final result reopens the input side at once.
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_end_of_run |=> in_ready && !out_valid)
    else $error("input not reopened after end of run");

  // A result that is not the final one is followed by more of the same run.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_end_of_run |=> !in_ready)
    else $error("run ended without end_of_run");

endmodule

bind ascending_integer_sorter_top asis_checker #(.DATA_WIDTH(DATA_WIDTH)) u_asis_checker (.*);

`default_nettype wire
